>>> hw/rtl/sdso_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdso_pkg
// Shared types and constants of the drifting sine oscillator.
// ----------------------------------------------------------------------------
package sdso_pkg;

    localparam logic signed [33:0] C0 = 34'sd3373182489;
    localparam logic signed [33:0] C1 = -34'sd2174083454;
    localparam logic signed [33:0] C2 = 34'sd555652804;
    localparam logic signed [33:0] C3 = -34'sd68387691;
    localparam logic signed [33:0] SHP_LIN = 34'sd1079110533;
    localparam logic signed [33:0] SHP_CUB = 34'sd53687091;
    localparam logic signed [33:0] DC_COEF = 34'sd536871;
    localparam logic [31:0] LCG_MUL = 32'd196314165;
    localparam logic [31:0] LCG_ADD = 32'd907633515;
    localparam logic signed [15:0] SYNC_THRESH = 16'sd16384;
    localparam logic [31:0] DEF_BASE_STEP = 32'd0;
    localparam logic [31:0] DEF_SEED = 32'd0;

    localparam logic [2:0] REG_SOFT = 3'd0;
    localparam logic [2:0] REG_DC = 3'd1;
    localparam logic [2:0] REG_CLK = 3'd2;
    localparam logic [2:0] REG_BASE = 3'd3;
    localparam logic [2:0] REG_SEED = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_WARM, ST_DIV, ST_LCG, ST_NOISE, ST_STEP, ST_T2,
        ST_H1, ST_H2, ST_H3, ST_TM, ST_Y, ST_YY, ST_SC, ST_SH,
        ST_DCM, ST_FIN, ST_OUT
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/sdso_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdso_div
// Serial restoring divider: 2^32 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdso_div import sdso_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [32:0]      o_quo
);
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [33:0] w_sh;

    assign o_done = r_busy && (r_cnt == 6'd0);
    assign o_quo  = r_quo;

    always_comb begin
        n_rem = r_rem; n_quo = r_quo; n_cnt = r_cnt; n_busy = r_busy; n_den = r_den;
        w_sh = {r_rem, (r_cnt == 6'd33)};  // dividend 2^32: msb first
        if (i_start) begin
            n_rem = '0; n_quo = '0; n_cnt = 6'd33; n_busy = 1'b1; n_den = i_den;
        end else if (r_busy && r_cnt != 6'd0) begin
            if (w_sh >= {2'b0, r_den}) begin
                n_rem = 33'(w_sh - {2'b0, r_den});
                n_quo = {r_quo[31:0], 1'b1};
            end else begin
                n_rem = w_sh[32:0];
                n_quo = {r_quo[31:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
        end else if (r_busy) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_quo <= n_quo; r_den <= n_den;
    end
endmodule
`default_nettype wire

>>> hw/rtl/sync_drift_sine_oscillator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_drift_sine_oscillator
// Phase accumulator oscillator with sync, random drift, polynomial sine,
// cubic shaper and DC blocker; all but the LCG multiply share one 34x34 multiplier.
// ----------------------------------------------------------------------------
// A clock-mode sync edge first runs the serial divider. The input waits until
// the output beat is taken. At most one multiply a cycle.
// Reset (synchronous, low): registers to defaults, then an LCG warm up; a seed
// write repeats that warm up. No beat is taken while busy.
module sync_drift_sine_oscillator import sdso_pkg::*; #(
    parameter logic [31:0] P_BASE_STEP = DEF_BASE_STEP,
    parameter logic [31:0] P_SEED = DEF_SEED
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] freq_step, [47:32] sync_level, [79:48] phase_offset,
    // [95:80] drift_amount
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] sample_out
    output logic [15:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    t_state r_st, n_st;
    logic r_soft, r_dcon, r_clk;
    logic [31:0] r_phase, r_cnt, r_rng, r_held;
    logic signed [31:0] r_dc;
    logic r_dir, r_was;
    logic [2:0] r_wc;
    logic signed [31:0] r_f;   // input step, later the applied step
    logic signed [15:0] r_drift;
    logic [31:0] r_p;
    logic signed [65:0] r_a;   // working accumulator
    logic signed [65:0] r_t, r_t2, r_h, r_y;
    logic [15:0] r_out;
    logic r_ov;

    // shared multiplier
    logic signed [33:0] m_a, m_b;
    logic signed [67:0] m_p;
    logic signed [65:0] m_q;
    assign m_p = m_a * m_b;
    assign m_q = 66'(m_p >>> 30);

    logic acc;
    assign s_axis_tready = (r_st == ST_IDLE) && !r_ov;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    logic w_high, w_edge;
    logic [31:0] w_cnt1;
    assign w_high = $signed(s_axis_tdata[47:32]) >= SYNC_THRESH;
    assign w_edge = w_high && !r_was;
    assign w_cnt1 = r_cnt + 32'd1;
    logic signed [65:0] w_sig, w_res, w_rr;
    logic signed [33:0] w_u;

    logic div_start, div_done;
    logic [32:0] div_q;
    sdso_div u_div (.i_clk, .i_rst_n, .i_start(div_start), .i_den(w_cnt1),
                    .o_done(div_done), .o_quo(div_q));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (acc) n_st = (w_edge && r_clk && w_cnt1 != 32'd0) ? ST_DIV : ST_LCG;
            ST_WARM:  if (r_wc == 3'd7) n_st = ST_IDLE;
            ST_DIV:   if (div_done) n_st = ST_LCG;
            ST_LCG:   n_st = ST_NOISE;
            ST_NOISE: n_st = ST_STEP;
            ST_STEP:  n_st = ST_T2;
            ST_T2:    n_st = ST_H1;
            ST_H1:    n_st = ST_H2;
            ST_H2:    n_st = ST_H3;
            ST_H3:    n_st = ST_TM;
            ST_TM:    n_st = ST_Y;
            ST_Y:     n_st = ST_YY;
            ST_YY:    n_st = ST_SC;
            ST_SC:    n_st = ST_SH;
            ST_SH:    n_st = ST_DCM;
            ST_DCM:   n_st = ST_FIN;
            ST_FIN:   n_st = ST_OUT;
            ST_OUT:   n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
        // seed write restarts the warm up
        if (i_cfg_we && i_cfg_idx == REG_SEED) n_st = ST_WARM;
    end

    always_comb begin
        m_a = '0; m_b = '0;
        div_start = acc && w_edge && r_clk && (w_cnt1 != 32'd0);
        w_u = 34'(signed'(r_rng ^ 32'h8000_0000));
        w_sig = r_a;
        w_res = r_dcon ? (w_sig - 66'(r_dc) - r_h) : w_sig;
        w_rr = (w_res + 66'sd16384) >>> 15;
        unique case (r_st)
            ST_NOISE: begin m_a = w_u; m_b = 34'(r_drift); end
            ST_STEP:  begin m_a = 34'(r_f); m_b = 34'(r_a); end
            ST_T2:    begin m_a = 34'(r_t); m_b = 34'(r_t); end
            ST_H1, ST_H2, ST_H3: begin m_a = 34'(r_t2); m_b = 34'(r_h); end
            ST_TM:    begin m_a = 34'(r_t); m_b = 34'(r_t2 - (66'sd1 <<< 30)); end
            ST_Y:     begin m_a = 34'(r_a); m_b = 34'(r_h); end
            ST_YY:    begin m_a = 34'(r_y); m_b = 34'(r_y); end
            ST_SC:    begin m_a = SHP_CUB; m_b = 34'(r_a); end
            ST_SH:    begin m_a = 34'(r_y); m_b = 34'(66'(SHP_LIN) - r_a); end
            ST_DCM:   begin m_a = DC_COEF; m_b = 34'(r_a - 66'(r_dc)); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_WARM; r_soft <= 1'b0; r_dcon <= 1'b1; r_clk <= 1'b0;
            r_held <= P_BASE_STEP; r_rng <= P_SEED;
            r_phase <= '0; r_cnt <= '0; r_dc <= '0; r_dir <= 1'b0;
            r_was <= 1'b0; r_wc <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            if (r_st == ST_WARM) r_wc <= r_wc + 3'd1;
            if (r_st == ST_WARM || r_st == ST_LCG) r_rng <= r_rng * LCG_MUL + LCG_ADD;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SOFT: r_soft <= i_cfg_data[0];
                    REG_DC:   r_dcon <= i_cfg_data[0];
                    REG_CLK:  begin r_clk <= i_cfg_data[0]; r_cnt <= '0; end
                    REG_BASE: r_held <= i_cfg_data;
                    REG_SEED: begin
                        r_rng <= i_cfg_data; r_wc <= '0;
                        r_phase <= '0; r_dc <= '0;
                        r_was <= 1'b0; r_dir <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (acc) begin
                r_cnt <= (w_edge && r_clk) ? 32'd0 : w_cnt1;
                r_was <= w_high;
                if (w_edge) begin
                    if (r_clk) r_phase <= '0;
                    else if (r_soft) r_dir <= ~r_dir;
                    else r_phase <= '0;
                end
            end
            if (r_st == ST_DIV && div_done)
                r_held <= (div_q > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
            if (r_st == ST_FIN) begin
                if (r_dcon) r_dc <= 32'(66'(r_dc) + r_h);
                else r_dc <= '0;
            end
            if (r_st == ST_OUT) begin
                r_phase <= r_phase + unsigned'(r_f);
                r_ov <= 1'b1;
            end
        end
        if (acc) begin
            r_f <= signed'(s_axis_tdata[31:0]);
            r_drift <= signed'(s_axis_tdata[95:80]);
            r_p <= s_axis_tdata[79:48];
        end
        unique case (r_st)
            ST_LCG: begin
                if (r_f == 32'sd0) r_f <= signed'(r_held);
                r_t <= 66'(signed'(r_phase + r_p ^ 32'h8000_0000)) >>> 1;
            end
            ST_NOISE: r_a <= (66'sd1 <<< 24) + (66'(m_p) >>> 20);
            ST_STEP: begin
                // step kept modulo 2^32 for the phase update
                r_f <= r_dir ? -32'(m_p >>> 24) : 32'(m_p >>> 24);
                r_h <= 66'(C3);
            end
            ST_T2: r_t2 <= m_q;
            ST_H1: r_h <= 66'(C2) + m_q;
            ST_H2: r_h <= 66'(C1) + m_q;
            ST_H3: r_h <= 66'(C0) + m_q;
            ST_TM: r_a <= m_q;
            ST_Y:  r_y <= m_q;
            ST_YY: r_a <= m_q;
            ST_SC: r_a <= m_q;
            ST_SH: r_a <= m_q;
            ST_DCM: r_h <= m_q;
            ST_FIN: begin
                if (w_rr > 66'sd32767) r_out <= 16'h7FFF;
                else if (w_rr < -66'sd32768) r_out <= 16'h8000;
                else r_out <= w_rr[15:0];
            end
            default: ;
        endcase
    end

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_out)))
        else $error("output beat changed while stalled");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_st == ST_IDLE))
        else $error("ready while busy");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT) |-> !r_ov)
        else $error("result overwritten");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
endmodule
`default_nettype wire

>>> tb/sv/sync_drift_sine_oscillator_tb.sv
// ----------------------------------------------------------------------------
// sync_drift_sine_oscillator_tb
// Streams input beats into the drifting sine oscillator and compares
// every output sample with a bit-exact software model of the same datapath,
// across sync modes, DC blocker settings, held steps and seeds.
// ----------------------------------------------------------------------------
module sync_drift_sine_oscillator_tb import sdso_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 120;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] freq_step, [47:32] sync_level, [79:48] phase_offset, [95:80] drift_amount
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] sample_out
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    sync_drift_sine_oscillator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state
    logic        m_soft, m_dc_on, m_clk_mode;
    logic [31:0] m_seed, m_phase, m_count, m_rng, m_held;
    logic        m_back, m_was_high;
    logic signed [31:0] m_dc;

    logic [15:0] sample_queue[$];
    int          errors = 0;
    bit          idle_en = 1'b1;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic [31:0] lcg_next(logic [31:0] s);
        return s * LCG_MUL + LCG_ADD;
    endfunction

    task automatic model_reseed();
        m_rng = m_seed;
        repeat (8) m_rng = lcg_next(m_rng);
        m_phase = '0;
        m_dc = '0;
        m_was_high = 1'b0;
        m_back = 1'b0;
    endtask

    function automatic longint sine_of(logic [31:0] p);
        longint t, t2, h;
        logic [31:0] x;
        x = p ^ 32'h8000_0000;
        t = longint'($signed(x)) >>> 1;
        t2 = qmul(t, t);
        h = longint'(C3);
        h = longint'(C2) + qmul(t2, h);
        h = longint'(C1) + qmul(t2, h);
        h = longint'(C0) + qmul(t2, h);
        return qmul(qmul(t, t2 - (longint'(1) << 30)), h);
    endfunction

    task automatic predict_sample(logic [95:0] d);
        longint f, lvl, drift, u, noise, stp, sig, res, dcv;
        logic [31:0] off, x;
        logic [63:0] q;
        bit high;
        f = longint'($signed(d[31:0]));
        lvl = longint'($signed(d[47:32]));
        off = d[79:48];
        drift = longint'($signed(d[95:80]));
        high = lvl >= 16384;
        m_count = m_count + 1;
        if (high && !m_was_high) begin
            if (m_clk_mode) begin
                if (m_count != 0) begin
                    q = (64'd1 << 32) / {32'd0, m_count};
                    m_held = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
                end
                m_count = '0;
                m_phase = '0;
            end else if (m_soft) begin
                m_back = ~m_back;
            end else begin
                m_phase = '0;
            end
        end
        m_was_high = high;
        if (f == 0) f = longint'($signed(m_held));
        m_rng = lcg_next(m_rng);
        x = m_rng ^ 32'h8000_0000;
        u = longint'($signed(x));
        noise = floor_shr(u * drift, 20);
        stp = floor_shr(f * ((longint'(1) << 24) + noise), 24);
        if (m_back) stp = -stp;
        sig = sine_of(m_phase + off);
        sig = qmul(sig, longint'(SHP_LIN) - qmul(longint'(SHP_CUB), qmul(sig, sig)));
        if (m_dc_on) begin
            dcv = longint'(m_dc);
            dcv = dcv + qmul(longint'(DC_COEF), sig - dcv);
            m_dc = dcv[31:0];
            res = sig - dcv;
        end else begin
            m_dc = '0;
            res = sig;
        end
        m_phase = m_phase + stp[31:0];
        res = floor_shr(res + (longint'(1) << 14), 15);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        sample_queue.push_back(res[15:0]);
    endtask

    task automatic random_gap();
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    task automatic send_sample(logic [31:0] fs, logic [15:0] lvl, logic [31:0] off,
                               logic [15:0] drift);
        random_gap();
        s_axis_tdata <= {drift, off, lvl, fs};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_sample({drift, off, lvl, fs});
        @(negedge i_clk);
    endtask

    // receiver with random backpressure
    always @(negedge i_clk) begin
        if (idle_en && $urandom_range(0, 5) == 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sample_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected sample %h", m_axis_tdata);
            end else begin
                if (m_axis_tdata !== sample_queue[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("sample mismatch: expected %h actual %h",
                                 sample_queue[0], m_axis_tdata);
                end
                void'(sample_queue.pop_front());
            end
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sample_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SOFT: m_soft = val[0];
            REG_DC: m_dc_on = val[0];
            REG_CLK: begin m_clk_mode = val[0]; m_count = '0; end
            REG_BASE: m_held = val;
            REG_SEED: begin m_seed = val; model_reseed(); end
            default: ;
        endcase
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_level();
        return ($urandom_range(0, 1)) ? 16'(20000 + $urandom_range(0, 12000))
                                      : 16'($urandom);
    endfunction

    task automatic test_directed();
        send_sample(32'h0100_0000, 16'h0000, 32'h0, 16'h0000);
        send_sample(32'h7FFF_FFFF, 16'h7FFF, 32'hFFFF_FFFF, 16'h7FFF);
        send_sample(32'h8000_0000, 16'h8000, 32'h8000_0000, 16'h8000);
        send_sample(32'h0, 16'h0000, 32'h4000_0000, 16'h0000);
        send_sample(32'h7FFF_FFFF, 16'h4000, 32'hC000_0000, 16'h7FFF);
        send_sample(32'h8000_0001, 16'h3FFF, 32'h0, 16'h8000);
        send_sample(32'h0000_0001, 16'h4000, 32'h2000_0000, 16'hFFFF);
        send_sample(32'hFFFF_FFFF, 16'h0000, 32'hE000_0000, 16'h0001);
    endtask

    task automatic test_hard_sync(int n);
        for (int i = 0; i < n; i++)
            send_sample($urandom_range(0, 7) == 0 ? 32'h0 : $urandom, rand_level(),
                        $urandom, $urandom_range(0, 1) ? 16'($urandom_range(0, 600)) : 16'($urandom));
    endtask

    task automatic test_soft_sync();
        for (int i = 0; i < 150; i++)
            send_sample($urandom_range(0, 3) == 0 ? 32'h0 : $urandom >> $urandom_range(0, 8),
                        rand_level(), $urandom, 16'($urandom));
    endtask

    task automatic test_clock_mode();
        int per;
        // two sync intervals of two beats, then random periods
        send_sample(32'h0, 16'h0000, 32'h0, 16'h0);
        send_sample(32'h0, 16'h7000, 32'h0, 16'h0);
        send_sample(32'h0, 16'h0000, 32'h0, 16'h0);
        send_sample(32'h0, 16'h7000, 32'h0, 16'h0);
        for (int k = 0; k < 25; k++) begin
            per = $urandom_range(1, 12);
            for (int j = 0; j < per; j++)
                send_sample($urandom_range(0, 3) == 0 ? $urandom : 32'h0,
                            j == per - 1 ? 16'h6000 : 16'h1000, $urandom,
                            16'($urandom_range(0, 3000)));
        end
    endtask

    task automatic test_noise();
        for (int i = 0; i < 150; i++)
            send_sample($urandom, 16'($urandom), $urandom, 16'($urandom));
    endtask

    initial begin
        m_soft = 1'b0; m_dc_on = 1'b1; m_clk_mode = 1'b0;
        m_seed = '0; m_held = '0; m_count = '0;
        model_reseed();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_hard_sync(150);
        write_reg(REG_SOFT, 32'd1);
        write_reg(REG_BASE, 32'h8000_0000);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        test_soft_sync();
        write_reg(REG_DC, 32'd0);
        write_reg(REG_BASE, 32'h7FFF_FFFF);
        test_noise();
        write_reg(REG_CLK, 32'd1);
        write_reg(REG_DC, 32'd1);
        test_clock_mode();
        write_reg(REG_CLK, 32'd0);
        write_reg(REG_SOFT, 32'd0);
        write_reg(REG_SEED, $urandom);
        write_reg(REG_BASE, $urandom);
        write_reg(REG_UNUSED, $urandom);
        idle_en = 1'b0;
        test_hard_sync(150);
        wait_drained();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/sdso_pkg.sv
hw/rtl/sdso_div.sv
hw/rtl/sync_drift_sine_oscillator.sv
tb/sv/sync_drift_sine_oscillator_tb.sv
